// ===== rtl/sc1eq_pkg.sv =====
// Package with the status codes, prefix bytes and key presence tables of the scan code queue.
`timescale 1ns / 1ps

package sc1eq_pkg;

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_NOEVENT = 3'd1,
        ST_DROPPED = 3'd2,
        ST_READ    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic {
        REQ_SCAN = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    localparam logic [7:0] PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] PREFIX_PAUSE = 8'hE1;

    // Bit i marks key index i as present.
    localparam logic [127:0] NORMAL_KEYS =
        128'h00000000_018FFFFF_FFFFFFFF_FFFFFFFE;
    localparam logic [127:0] EXT_KEYS =
        128'h00000000_3807AB80_01A00000_30000000;

    // Stored event layout: {released, extended, key_index}.
    typedef struct packed {
        logic       released;
        logic       extended;
        logic [6:0] key_index;
    } key_event_t;

endpackage

// ===== rtl/scancode_set1_event_queue_top.sv =====
// Set 1 scan code decoder feeding a ring buffer of key events.
// The result of an accepted request is registered and appears on the m_ side in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; the ring memory has one write and one read port.
// The result register frees while its result is taken, so requests never wait on an empty slot.
// Reset (synchronous, active low) clears both prefix flags, both ring pointers and the
// result valid; the ring memory itself is not cleared, since only written entries are read.
`timescale 1ns / 1ps

module scancode_set1_event_queue_top #(
    parameter int DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [6:0] m_key_index,
    output logic       m_extended,
    output logic       m_released,
    output logic [7:0] m_pending_count
);
    import sc1eq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    key_event_t ring_mem [DEPTH];

    logic             ext_prefix_reg, ext_prefix_next;
    logic             pause_prefix_reg, pause_prefix_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic             m_valid_reg;
    status_t          status_reg, status_next;
    logic [7:0]       pending_reg, pending_next;
    key_event_t       rd_data_reg;

    logic             accept;
    logic             key_valid;
    logic             key_ext;
    logic             do_write;
    logic             do_read;
    logic [PTR_W-1:0] read_ptr_inc;
    logic [PTR_W-1:0] write_ptr_inc;
    logic [CNT_W-1:0] diff;
    logic [31:0]      diff_wide;
    key_event_t       wr_event;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign read_ptr_inc  = (read_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : read_ptr_reg + 1'b1;
    assign write_ptr_inc = (write_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : write_ptr_reg + 1'b1;

    assign wr_event = '{released: s_scan_byte[7], extended: key_ext,
                        key_index: s_scan_byte[6:0]};

    always_comb begin
        ext_prefix_next   = ext_prefix_reg;
        pause_prefix_next = pause_prefix_reg;
        read_ptr_next     = read_ptr_reg;
        write_ptr_next    = write_ptr_reg;
        status_next       = ST_NOEVENT;
        key_valid         = 1'b0;
        key_ext           = 1'b0;
        do_write          = 1'b0;
        do_read           = 1'b0;

        if (s_req_type == REQ_READ) begin
            if (read_ptr_reg == write_ptr_reg) begin
                status_next = ST_EMPTY;
            end else begin
                do_read       = 1'b1;
                read_ptr_next = read_ptr_inc;
                status_next   = ST_READ;
            end
        end else begin
            if (s_scan_byte == PREFIX_EXT) begin
                ext_prefix_next = 1'b1;
            end else if (s_scan_byte == PREFIX_PAUSE) begin
                pause_prefix_next = 1'b1;
            end else if (ext_prefix_reg) begin
                // The extended prefix is served before a pending pause prefix.
                key_ext         = 1'b1;
                key_valid       = EXT_KEYS[s_scan_byte[6:0]];
                ext_prefix_next = 1'b0;
            end else if (pause_prefix_reg) begin
                pause_prefix_next = 1'b0;
            end else begin
                key_valid = NORMAL_KEYS[s_scan_byte[6:0]];
            end

            if (key_valid) begin
                if (write_ptr_inc == read_ptr_reg) begin
                    status_next = ST_DROPPED;
                end else begin
                    do_write       = 1'b1;
                    write_ptr_next = write_ptr_inc;
                    status_next    = ST_QUEUED;
                end
            end
        end
    end

    // Fill level after this request, saturated to the 8-bit count.
    always_comb begin
        if (write_ptr_next >= read_ptr_next) begin
            diff = CNT_W'(write_ptr_next) - CNT_W'(read_ptr_next);
        end else begin
            diff = CNT_W'(write_ptr_next) + CNT_W'(DEPTH) - CNT_W'(read_ptr_next);
        end
        diff_wide    = 32'(diff);
        pending_next = (diff_wide > 32'd255) ? 8'hFF : diff_wide[7:0];
    end

    always_ff @(posedge aclk) begin
        if (accept && do_write) begin
            ring_mem[write_ptr_reg] <= wr_event;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && do_read) begin
            rd_data_reg <= ring_mem[read_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_prefix_reg   <= 1'b0;
            pause_prefix_reg <= 1'b0;
            read_ptr_reg     <= '0;
            write_ptr_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                ext_prefix_reg   <= ext_prefix_next;
                pause_prefix_reg <= pause_prefix_next;
                read_ptr_reg     <= read_ptr_next;
                write_ptr_reg    <= write_ptr_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            pending_reg <= pending_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_pending_count = pending_reg;
    assign m_key_index     = (status_reg == ST_READ) ? rd_data_reg.key_index : 7'd0;
    assign m_extended      = (status_reg == ST_READ) ? rd_data_reg.extended : 1'b0;
    assign m_released      = (status_reg == ST_READ) ? rd_data_reg.released : 1'b0;

endmodule

// ===== tb/tb_scancode_set1_event_queue_top.sv =====
// Testbench for the set 1 scan code event queue: directed, ring-full, stall and random checks.
`timescale 1ns / 1ps

module tb_scancode_set1_event_queue_top;
    import sc1eq_pkg::*;

    localparam int RING_DEPTH = 256;

    // Key presence maps; bit i marks key index i as a real key.
    localparam logic [127:0] MAIN_KEY_MAP = 128'h00000000_018FFFFF_FFFFFFFF_FFFFFFFE;
    localparam logic [127:0] EXT_KEY_MAP  = 128'h00000000_3807AB80_01A00000_30000000;

    typedef struct packed {
        status_t    status;
        logic [6:0] key_index;
        logic       extended;
        logic       released;
        logic [7:0] pending_count;
    } key_outcome_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [7:0] s_scan_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic [6:0] m_key_index;
    logic       m_extended;
    logic       m_released;
    logic [7:0] m_pending_count;

    // Shadow state of the decoder and its ring.
    bit          ext_armed;
    bit          pause_armed;
    key_event_t  ring [RING_DEPTH];
    int unsigned rd_idx;
    int unsigned wr_idx;

    key_outcome_t outcome_q [$];
    int unsigned  sent_count;
    int unsigned  errors;
    bit           tx_gaps_on = 1'b1;
    bit           rx_stalls_on = 1'b1;
    int unsigned  hold_off_req;
    int unsigned  rx_pause;

    scancode_set1_event_queue_top #(.DEPTH(RING_DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_scan_byte     (s_scan_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_key_index     (m_key_index),
        .m_extended      (m_extended),
        .m_released      (m_released),
        .m_pending_count (m_pending_count)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(20, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [6:0] pick_key(input bit from_ext);
        logic [6:0] k;
        do begin
            k = 7'($urandom_range(0, 127));
        end while (!(from_ext ? EXT_KEY_MAP[k] : MAIN_KEY_MAP[k]));
        return k;
    endfunction

    // Advances the shadow state by one request and returns the result it should give.
    function automatic key_outcome_t decode_request(input req_t req, input logic [7:0] b);
        key_outcome_t o;
        bit           hit;
        bit           is_ext;
        int unsigned  nxt;
        int unsigned  held;
        o = '{status: ST_NOEVENT, key_index: 7'd0, extended: 1'b0, released: 1'b0,
              pending_count: 8'd0};
        hit = 1'b0;
        is_ext = 1'b0;
        if (req == REQ_READ) begin
            if (rd_idx == wr_idx) begin
                o.status = ST_EMPTY;
            end else begin
                o.key_index = ring[rd_idx].key_index;
                o.extended  = ring[rd_idx].extended;
                o.released  = ring[rd_idx].released;
                rd_idx = (rd_idx + 1) % RING_DEPTH;
                o.status = ST_READ;
            end
        end else begin
            if (b == PREFIX_EXT) begin
                ext_armed = 1'b1;
            end else if (b == PREFIX_PAUSE) begin
                pause_armed = 1'b1;
            end else if (ext_armed) begin
                // The extended prefix wins over an armed pause prefix.
                is_ext = 1'b1;
                hit = EXT_KEY_MAP[b[6:0]];
                ext_armed = 1'b0;
            end else if (pause_armed) begin
                pause_armed = 1'b0;
            end else begin
                hit = MAIN_KEY_MAP[b[6:0]];
            end
            if (hit) begin
                nxt = (wr_idx + 1) % RING_DEPTH;
                if (nxt == rd_idx) begin
                    o.status = ST_DROPPED;
                end else begin
                    ring[wr_idx] = {b[7], is_ext, b[6:0]};
                    wr_idx = nxt;
                    o.status = ST_QUEUED;
                end
            end
        end
        held = (wr_idx + RING_DEPTH - rd_idx) % RING_DEPTH;
        o.pending_count = (held > 255) ? 8'd255 : held[7:0];
        return o;
    endfunction

    task automatic send_item(input req_t req, input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
        end
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_scan_byte <= b;
        do @(posedge aclk); while (!s_ready);
        outcome_q.push_back(decode_request(req, b));
        sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_scan(input logic [7:0] b);
        send_item(REQ_SCAN, b);
    endtask

    task automatic send_read();
        send_item(REQ_READ, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: random short and long stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_off_req != 0) begin
            rx_pause = hold_off_req;
            hold_off_req = 0;
        end else if (rx_pause == 0 && rx_stalls_on && $urandom_range(0, 3) == 0) begin
            rx_pause = gap_len();
        end
        if (rx_pause != 0) begin
            m_ready <= 1'b0;
            rx_pause--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        key_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no request pending, status %0d", $time, m_status);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, m_status);
                    errors++;
                end
                if (m_key_index !== want.key_index) begin
                    $display("%0t: key_index expected %0d, got %0d",
                             $time, want.key_index, m_key_index);
                    errors++;
                end
                if (m_extended !== want.extended) begin
                    $display("%0t: extended expected %0b, got %0b",
                             $time, want.extended, m_extended);
                    errors++;
                end
                if (m_released !== want.released) begin
                    $display("%0t: released expected %0b, got %0b",
                             $time, want.released, m_released);
                    errors++;
                end
                if (m_pending_count !== want.pending_count) begin
                    $display("%0t: pending_count expected %0d, got %0d",
                             $time, want.pending_count, m_pending_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_read();                    // read while the ring is empty
        send_scan(8'h00);               // index 0 is not a key
        send_scan(8'h01);
        send_scan(8'h81);
        send_scan(PREFIX_EXT);
        send_scan(PREFIX_EXT);          // prefix again while already armed
        send_scan(8'h1D);
        send_scan(PREFIX_EXT);
        send_scan(8'h9C);
        send_scan(PREFIX_EXT);
        send_scan(8'h01);               // unknown extended key still uses up the prefix
        send_scan(8'hFF);
        send_scan(PREFIX_PAUSE);
        send_scan(8'h1D);               // swallowed
        send_scan(PREFIX_PAUSE);
        send_scan(PREFIX_EXT);
        send_scan(8'h38);               // both armed: extended first
        send_scan(8'h45);               // then the pause prefix swallows this one
        repeat (6) send_read();
        wait_idle();
    endtask

    task automatic test_ring_full();
        repeat (RING_DEPTH) send_scan({1'($urandom_range(0, 1)), pick_key(1'b0)});
        send_scan(PREFIX_EXT);
        send_scan({1'($urandom_range(0, 1)), pick_key(1'b1)});
        repeat (RING_DEPTH) send_read();
        wait_idle();
    endtask

    // The receiver holds off while requests keep coming, so the block must stall its input.
    task automatic test_output_stall();
        hold_off_req = 300;
        repeat (30) begin
            if ($urandom_range(0, 2) == 0) begin
                send_read();
            end else begin
                send_scan({1'($urandom_range(0, 1)), pick_key(1'b0)});
            end
        end
        wait_idle();
    endtask

    task automatic test_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = sent_count + target;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 39) == 0) begin
                tx_gaps_on   = ($urandom_range(0, 2) != 0);
                rx_stalls_on = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 34) begin
                send_scan({1'($urandom_range(0, 1)), pick_key(1'b0)});
            end else if (pick < 48) begin
                send_scan(PREFIX_EXT);
                send_scan({1'($urandom_range(0, 1)), pick_key(1'b1)});
            end else if (pick < 52) begin
                // The pause key sends its whole make and break sequence at once.
                send_scan(PREFIX_PAUSE);
                send_scan(8'h1D);
                send_scan(8'h45);
                send_scan(PREFIX_PAUSE);
                send_scan(8'h9D);
                send_scan(8'hC5);
            end else if (pick < 82) begin
                send_read();
            end else if (pick < 94) begin
                send_scan(8'($urandom_range(0, 255)));
            end else if (pick < 99) begin
                repeat ($urandom_range(2, 8)) send_read();
            end else begin
                wait_idle();
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_ring_full();
        test_output_stall();
        test_random(1050);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sc1eq_pkg.sv
rtl/scancode_set1_event_queue_top.sv
tb/tb_scancode_set1_event_queue_top.sv
